// ===== src/pla_pkg.sv =====
package pla_pkg;

    localparam int COORD_BITS = 24;
    localparam int SUM_BITS   = 48;
    localparam int COUNT_BITS = 20;
    localparam int ROOT_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * ROOT_BITS;
    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int REM_BITS   = ROOT_BITS + 2;
    localparam int STEP_BITS  = $clog2(ROOT_BITS);

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_ACC,
        ST_ROOT,
        ST_ACCUM,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic  load;
        logic  mul_en;
        t_axis mul_sel;
        logic  acc_clr;
        logic  acc_en;
        logic  root_step;
        logic  sum_add;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic have_prev;
        logic final_pt;
        logic final_in;
        logic out_busy;
    } t_status;

endpackage

// ===== src/pla_ctrl.sv =====
module pla_ctrl import pla_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state                 r_state;
    t_state                 n_state;
    logic [STEP_BITS-1:0]   r_step;
    logic [STEP_BITS-1:0]   n_step;
    logic                   w_accept;
    logic                   w_last_step;

    assign o_stall     = (r_state != ST_IDLE);
    assign w_accept    = i_valid && (r_state == ST_IDLE);
    assign w_last_step = (r_step == STEP_BITS'(ROOT_BITS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_status.have_prev) begin
                        n_state = ST_SQ_X;
                    end else if (i_status.final_in) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SQ_X:   n_state = ST_SQ_Y;
            ST_SQ_Y:   n_state = ST_SQ_Z;
            ST_SQ_Z:   n_state = ST_SQ_ACC;
            ST_SQ_ACC: n_state = ST_ROOT;
            ST_ROOT: begin
                if (w_last_step) begin
                    n_state = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                n_state = i_status.final_pt ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                if (!i_status.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (r_state == ST_SQ_ACC) begin
            n_step = '0;
        end else if (r_state == ST_ROOT) begin
            n_step = r_step + STEP_BITS'(1);
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = AXIS_X;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = w_accept;
            end
            ST_SQ_X: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = AXIS_X;
                o_cmd.acc_clr = 1'b1;
            end
            ST_SQ_Y: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = AXIS_Y;
                o_cmd.acc_en  = 1'b1;
            end
            ST_SQ_Z: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = AXIS_Z;
                o_cmd.acc_en  = 1'b1;
            end
            ST_SQ_ACC: begin
                o_cmd.acc_en = 1'b1;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
            end
            ST_ACCUM: begin
                o_cmd.sum_add = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.out_load = !i_status.out_busy;
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== src/pla_datapath.sv =====
module pla_datapath import pla_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    input  logic                         i_final_point,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [SUM_BITS-1:0]          o_total_length,
    output logic [COUNT_BITS-1:0]        o_point_count,
    output logic                         o_saturated,
    input  t_cmd                         i_cmd,
    output t_status                      o_status
);

    logic signed [COORD_BITS-1:0] r_prev_x, r_prev_y, r_prev_z;
    logic                         r_have_prev;
    logic                         r_final;
    logic [COORD_BITS-1:0]        r_dx, r_dy, r_dz;
    logic [PROD_BITS-1:0]         r_prod;
    logic [SQ_BITS-1:0]           r_acc;
    logic [REM_BITS-1:0]          r_rem;
    logic [ROOT_BITS-1:0]         r_root;
    logic [SUM_BITS-1:0]          r_sum;
    logic [COUNT_BITS-1:0]        r_count;
    logic                         r_ovf;
    logic                         r_out_valid;
    logic [SUM_BITS-1:0]          r_out_len;
    logic [COUNT_BITS-1:0]        r_out_cnt;
    logic                         r_out_sat;

    logic [COORD_BITS-1:0]        w_ax, w_ay, w_az;
    logic [COORD_BITS-1:0]        w_mul_a;
    logic [REM_BITS+1:0]          w_rem_sh;
    logic [REM_BITS+1:0]          w_trial;
    logic                         w_fit;
    logic [SUM_BITS:0]            w_sum_ext;
    logic                         w_out_take;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        logic [COORD_BITS:0]        m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? (~d + (COORD_BITS+1)'(1)) : d;
        return m[COORD_BITS-1:0];
    endfunction

    assign w_ax = abs_diff(i_coord_x, r_prev_x);
    assign w_ay = abs_diff(i_coord_y, r_prev_y);
    assign w_az = abs_diff(i_coord_z, r_prev_z);

    always_comb begin
        unique case (i_cmd.mul_sel)
            AXIS_X:  w_mul_a = r_dx;
            AXIS_Y:  w_mul_a = r_dy;
            AXIS_Z:  w_mul_a = r_dz;
            default: w_mul_a = '0;
        endcase
    end

    assign w_rem_sh  = {r_rem, r_acc[SQ_BITS-1 -: 2]};
    assign w_trial   = {2'b00, r_root, 2'b01};
    assign w_fit     = (w_rem_sh >= w_trial);
    assign w_sum_ext = {1'b0, r_sum} + (SUM_BITS+1)'(r_root);
    assign w_out_take = r_out_valid && !i_stall;

    assign o_status.have_prev = r_have_prev;
    assign o_status.final_pt  = r_final;
    assign o_status.final_in  = i_final_point;
    assign o_status.out_busy  = r_out_valid && i_stall;

    assign o_valid        = r_out_valid;
    assign o_total_length = r_out_len;
    assign o_point_count  = r_out_cnt;
    assign o_saturated    = r_out_sat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx    <= w_ax;
            r_dy    <= w_ay;
            r_dz    <= w_az;
            r_final <= i_final_point;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_mul_a * w_mul_a;
        end
        if (i_cmd.acc_clr) begin
            r_acc  <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + SQ_BITS'(r_prod);
        end else if (i_cmd.root_step) begin
            r_acc <= {r_acc[SQ_BITS-3:0], 2'b00};
            if (w_fit) begin
                r_rem  <= REM_BITS'(w_rem_sh - w_trial);
                r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[REM_BITS-1:0];
                r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_out_len <= r_sum;
            r_out_cnt <= r_count;
            r_out_sat <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
            r_have_prev <= 1'b0;
            r_sum       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_prev_x    <= i_coord_x;
                r_prev_y    <= i_coord_y;
                r_prev_z    <= i_coord_z;
                r_have_prev <= 1'b1;
                if (r_count != '1) begin
                    r_count <= r_count + COUNT_BITS'(1);
                end
            end
            if (i_cmd.sum_add) begin
                if (w_sum_ext[SUM_BITS]) begin
                    r_sum <= '1;
                    r_ovf <= 1'b1;
                end else begin
                    r_sum <= w_sum_ext[SUM_BITS-1:0];
                end
            end
            if (i_cmd.out_load) begin
                r_prev_x    <= '0;
                r_prev_y    <= '0;
                r_prev_z    <= '0;
                r_have_prev <= 1'b0;
                r_sum       <= '0;
                r_count     <= '0;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== src/polyline_arclength.sv =====
// Sequence: the first point of a polyline only becomes the previous point; each later point
//   goes through shared squaring and accumulation, the 25-step restoring square root and the add.
// A final point then loads the result beat, waiting while the previous beat is stalled.
// o_stall holds off new points in every state but idle; a single-point polyline goes straight to the result.
// Reset: synchronous, active low; clears the running total, count, previous point
//   and the output valid.
module polyline_arclength import pla_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    input  logic                         i_final_point,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [SUM_BITS-1:0]          o_total_length,
    output logic [COUNT_BITS-1:0]        o_point_count,
    output logic                         o_saturated
);

    t_cmd    w_cmd;
    t_status w_status;

    pla_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    pla_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_final_point  (i_final_point),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_total_length (o_total_length),
        .o_point_count  (o_point_count),
        .o_saturated    (o_saturated),
        .i_cmd          (w_cmd),
        .o_status       (w_status)
    );

endmodule

// ===== src/pla_checker.sv =====
module pla_checker import pla_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_stall,
    input  logic                         i_final_point,
    input  logic                         o_valid,
    input  logic                         i_stall,
    input  logic [SUM_BITS-1:0]          o_total_length,
    input  logic [COUNT_BITS-1:0]        o_point_count,
    input  logic                         o_saturated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_total_length) && $stable(o_point_count)
            && $stable(o_saturated))
        else $error("output beat changed while stalled");

    a_stall_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_final_point |=> o_stall)
        else $error("input not held off after a final point");

    a_sat_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> (&o_total_length))
        else $error("saturated beat without maximum length");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_point_count != '0))
        else $error("result beat with zero points");

endmodule

bind polyline_arclength pla_checker u_pla_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pla_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_BITS) - 1;
    localparam int COUNT_LIMIT = (1 << COUNT_BITS) - 1;
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct {
        logic [SUM_BITS-1:0]   total;
        logic [COUNT_BITS-1:0] count;
        logic                  sat;
    } t_polyline_sum;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic signed [COORD_BITS-1:0] i_coord_x;
    logic signed [COORD_BITS-1:0] i_coord_y;
    logic signed [COORD_BITS-1:0] i_coord_z;
    logic                         i_final_point;
    logic                         o_valid;
    logic                         i_stall;
    logic [SUM_BITS-1:0]          o_total_length;
    logic [COUNT_BITS-1:0]        o_point_count;
    logic                         o_saturated;

    logic rand_stall;
    logic hold_stall;
    bit   steady;

    logic signed [COORD_BITS-1:0] last_x, last_y, last_z;
    bit                           have_last;
    longint unsigned              run_total;
    int                           run_count;
    bit                           run_sat;

    t_polyline_sum pending_sums[$];

    int errors;
    int points_sent;
    int sums_checked;
    int input_stalls;

    assign i_stall = rand_stall | hold_stall;

    polyline_arclength dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_final_point  (i_final_point),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_total_length (o_total_length),
        .o_point_count  (o_point_count),
        .o_saturated    (o_saturated)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned floor_root(input longint unsigned sq);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = ROOT_BITS; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= sq) begin
                root = cand;
            end
        end
        return root;
    endfunction

    task automatic walk_point(input logic signed [COORD_BITS-1:0] x, y, z,
                              input logic fin);
        longint dx, dy, dz;
        longint unsigned seg;
        t_polyline_sum res;
        if (have_last) begin
            dx = longint'(x) - longint'(last_x);
            dy = longint'(y) - longint'(last_y);
            dz = longint'(z) - longint'(last_z);
            seg = floor_root(longint'(dx * dx + dy * dy + dz * dz));
            if (seg > SUM_LIMIT - run_total) begin
                run_total = SUM_LIMIT;
                run_sat = 1'b1;
            end else begin
                run_total += seg;
            end
        end
        last_x = x;
        last_y = y;
        last_z = z;
        have_last = 1'b1;
        if (run_count < COUNT_LIMIT) begin
            run_count++;
        end
        if (fin) begin
            res.total = run_total[SUM_BITS-1:0];
            res.count = run_count[COUNT_BITS-1:0];
            res.sat = run_sat;
            pending_sums = {pending_sums, res};
            last_x = '0;
            last_y = '0;
            last_z = '0;
            have_last = 1'b0;
            run_total = 0;
            run_count = 0;
            run_sat = 1'b0;
        end
    endtask

    task automatic send_point(input logic signed [COORD_BITS-1:0] x, y, z,
                              input logic fin);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_coord_x = x;
        i_coord_y = y;
        i_coord_z = z;
        i_final_point = fin;
        i_valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
            input_stalls++;
        end
        walk_point(x, y, z, fin);
        points_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [COORD_BITS-1:0] pick_coord(
        input logic signed [COORD_BITS-1:0] near);
        logic signed [COORD_BITS-1:0] step;
        step = COORD_BITS'($urandom_range(0, 512));
        step = step - 256;
        case ($urandom_range(0, 9))
            5, 6, 7: return near + step;
            8:       return C_MAX;
            9:       return C_MIN;
            default: return COORD_BITS'($urandom());
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want, got);
        errors++;
        if (errors <= 10) begin
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_polyline_sum want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_sums.size() == 0) begin
                flag_mismatch("unexpected beat", 64'd0, 64'(o_total_length));
            end else begin
                want = pending_sums.pop_front();
                sums_checked++;
                if (o_total_length !== want.total) begin
                    flag_mismatch("total_length", 64'(want.total), 64'(o_total_length));
                end
                if (o_point_count !== want.count) begin
                    flag_mismatch("point_count", 64'(want.count), 64'(o_point_count));
                end
                if (o_saturated !== want.sat) begin
                    flag_mismatch("saturated", 64'(want.sat), 64'(o_saturated));
                end
            end
        end
    end

    initial begin
        int wait_n;
        rand_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            wait_n = steady ? 0 : $urandom_range(0, 6);
            if (wait_n > 0) begin
                rand_stall = 1'b1;
                repeat (wait_n) @(negedge i_clk);
                rand_stall = 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            @(negedge i_clk);
        end
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic test_single_points();
        send_point(C_MAX, C_MAX, C_MAX, 1'b1);
        send_point(C_MIN, C_MAX, '0, 1'b1);
        send_point('1, C_MIN, C_MIN, 1'b1);
    endtask

    task automatic test_extreme_segments();
        send_point(C_MIN, C_MIN, C_MIN, 1'b0);
        send_point(C_MAX, C_MAX, C_MAX, 1'b1);
        send_point(C_MAX, C_MIN, C_MAX, 1'b0);
        send_point(C_MIN, C_MAX, C_MIN, 1'b1);
    endtask

    task automatic test_segment_rounding();
        send_point(24'sd0, 24'sd0, 24'sd0, 1'b0);
        send_point(24'sd1, 24'sd1, 24'sd0, 1'b0);
        send_point(24'sd1, 24'sd1, 24'sd0, 1'b0);
        send_point(24'sd2, 24'sd2, 24'sd1, 1'b1);
        send_point(-24'sd3, 24'sd0, 24'sd0, 1'b0);
        send_point(24'sd0, 24'sd4, 24'sd0, 1'b1);
    endtask

    task automatic test_mixed_signs();
        send_point(-24'sd256, 24'sd512, -24'sd768, 1'b0);
        send_point(24'sd256, -24'sd512, 24'sd768, 1'b0);
        send_point(C_MAX, 24'sd0, C_MIN, 1'b0);
        send_point(24'sd0, 24'sd0, 24'sd0, 1'b0);
        send_point(-24'sd1, -24'sd1, -24'sd1, 1'b1);
    endtask

    task automatic test_random_polylines();
        int len;
        logic signed [COORD_BITS-1:0] px, py, pz;
        px = '0;
        py = '0;
        pz = '0;
        while (points_sent < 525) begin
            steady = ($urandom_range(0, 4) == 0);
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(16, 40)
                                               : $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                px = pick_coord(px);
                py = pick_coord(py);
                pz = pick_coord(pz);
                send_point(px, py, pz, k == len - 1);
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        int len;
        steady = 1'b1;
        fork
            begin
                hold_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_stall = 1'b0;
            end
        join_none
        for (int p = 0; p < 8; p++) begin
            len = $urandom_range(2, 3);
            for (int k = 0; k < len; k++) begin
                send_point(pick_coord('0), pick_coord('0), pick_coord('0), k == len - 1);
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_coord_z = '0;
        i_final_point = 1'b0;
        hold_stall = 1'b0;
        steady = 1'b0;
        last_x = '0;
        last_y = '0;
        last_z = '0;
        have_last = 1'b0;
        run_total = 0;
        run_count = 0;
        run_sat = 1'b0;
        errors = 0;
        points_sent = 0;
        sums_checked = 0;
        input_stalls = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_single_points();
        test_extreme_segments();
        test_segment_rounding();
        test_mixed_signs();
        test_random_polylines();
        test_backpressure();
        i_valid = 1'b0;

        while (pending_sums.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_sums.size() > 0) begin
            errors += pending_sums.size();
            $display("%0d polyline results never arrived", pending_sums.size());
        end

        $display("Sent %0d points, checked %0d polyline lengths, %0d mismatches.",
                 points_sent, sums_checked, errors);
        $display("Input held off %0d cycles under a %0d-cycle output hold.",
                 input_stalls, HOLD_CYCLES);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
